// File: hw/rtl/rrat_pkg.sv
// ----------------------------------------------------------------------------
// rrat_pkg
// Shared types and codes for the request replay admission table.
// ----------------------------------------------------------------------------
package rrat_pkg;

  // Table geometry
  localparam int unsigned TABLE_SLOTS_DEF = 16;

  // Field widths
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned WINDOW_W  = 32;
  localparam int unsigned VERDICT_W = 4;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned CFG_IDX_W = 3;

  // Verdict codes
  localparam logic [VERDICT_W-1:0] V_BAD_IDENTITY = 4'd0;
  localparam logic [VERDICT_W-1:0] V_WRONG_DEVICE = 4'd1;
  localparam logic [VERDICT_W-1:0] V_WRONG_BOOT   = 4'd2;
  localparam logic [VERDICT_W-1:0] V_CONFLICT     = 4'd3;
  localparam logic [VERDICT_W-1:0] V_REPLAY       = 4'd4;
  localparam logic [VERDICT_W-1:0] V_EXPIRED      = 4'd5;
  localparam logic [VERDICT_W-1:0] V_BAD_WINDOW   = 4'd6;
  localparam logic [VERDICT_W-1:0] V_FULL         = 4'd7;
  localparam logic [VERDICT_W-1:0] V_ACCEPT       = 4'd8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_DEVICE_HI = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_DEVICE_LO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_BOOT_HI   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_BOOT_LO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS     = 3'd4;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd60000;

  // UUID layout: version nibble in the high half, variant bits in the low half
  localparam logic [3:0] UUID_VERSION = 4'h4;
  localparam logic [1:0] UUID_VARIANT = 2'b10;

  // One table entry as stored in the memory
  typedef struct packed {
    logic [WORD_W-1:0] id_hi;
    logic [WORD_W-1:0] id_lo;
    logic [WORD_W-1:0] expiry;
    logic [WORD_W-1:0] digest;
  } entry_t;

endpackage

// File: hw/rtl/rrat_if.sv
// ----------------------------------------------------------------------------
// rrat_if
// Valid/ready channels for requests and verdicts.
// ----------------------------------------------------------------------------
interface rrat_in_if;
  logic                       valid;
  logic                       ready;
  logic [rrat_pkg::WORD_W-1:0] request_hi;
  logic [rrat_pkg::WORD_W-1:0] request_lo;
  logic [rrat_pkg::WORD_W-1:0] claimed_device_hi;
  logic [rrat_pkg::WORD_W-1:0] claimed_device_lo;
  logic [rrat_pkg::WORD_W-1:0] claimed_boot_hi;
  logic [rrat_pkg::WORD_W-1:0] claimed_boot_lo;
  logic                       text_form_ok;
  logic [rrat_pkg::WORD_W-1:0] expiry_ms;
  logic [rrat_pkg::WORD_W-1:0] now_ms;
  logic [rrat_pkg::WORD_W-1:0] digest;

  modport source (
    output valid, request_hi, request_lo, claimed_device_hi, claimed_device_lo,
           claimed_boot_hi, claimed_boot_lo, text_form_ok, expiry_ms, now_ms,
           digest,
    input  ready
  );
  modport sink (
    input  valid, request_hi, request_lo, claimed_device_hi, claimed_device_lo,
           claimed_boot_hi, claimed_boot_lo, text_form_ok, expiry_ms, now_ms,
           digest,
    output ready
  );
endinterface

interface rrat_out_if;
  logic                          valid;
  logic                          ready;
  logic [rrat_pkg::VERDICT_W-1:0] verdict;
  logic [rrat_pkg::SLOT_W-1:0]    slot_index;

  modport source (output valid, verdict, slot_index, input ready);
  modport sink   (input valid, verdict, slot_index, output ready);
endinterface

// File: hw/rtl/request_replay_admission_table_unit.sv
// ----------------------------------------------------------------------------
// request_replay_admission_table_unit
// Admits command requests: identity checks, table lookup, time window and capacity checks, append.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                      | transfer
//  --------+-----+----------------------------------------------+----------------
//  in_ch   | in  | request/device/boot ids, text flag, times,   | valid & ready
//          |     | digest                                       |
//  out_ch  | out | verdict, slot_index                          | valid & ready
//  cfg_*   | in  | index, 64-bit data                           | cfg_we
//
//  A miss shows its result once every entry below the count has been read, a
//  hit on slot i once that entry has been read, and a failed identity, device
//  or boot check straight after the check state: the table memory is scanned
//  one entry per cycle on its single registered read port. The next request
//  can be taken in the cycle after the result loads.
//  One item is in work at a time; the output register holds a finished
//  result so the next request can be taken while it waits.
//  Reset clears the entry count; table contents are never cleared and only
//  entries below the count are read. No clearing pass is needed.
// ----------------------------------------------------------------------------
module request_replay_admission_table_unit #(
  parameter int unsigned TABLE_SLOTS = rrat_pkg::TABLE_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rrat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrat_pkg::WORD_W-1:0]    cfg_wdata,
  rrat_in_if.sink                       in_ch,
  rrat_out_if.source                    out_ch
);

  localparam int unsigned IDX_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned COUNT_W = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned W       = rrat_pkg::WORD_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // Configuration registers
  logic [W-1:0]                  own_dev_hi_r, own_dev_lo_r;
  logic [W-1:0]                  own_boot_hi_r, own_boot_lo_r;
  logic [rrat_pkg::WINDOW_W-1:0] window_r;

  // Captured request
  logic [W-1:0] req_hi_r, req_lo_r, dev_hi_r, dev_lo_r, boot_hi_r, boot_lo_r;
  logic [W-1:0] expiry_r, now_r, digest_r;
  logic         text_ok_r;

  // Control
  logic [1:0]         state_r, state_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] scan_r, scan_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]   rd_idx_r;

  // Time checks latched in the check cycle
  logic         expired_r;
  logic [W-1:0] gap_r;

  // Pending result and output register
  logic [rrat_pkg::VERDICT_W-1:0] verdict_r, verdict_nxt;
  logic [rrat_pkg::SLOT_W-1:0]    slot_r, slot_nxt;
  logic                           out_valid_r;
  logic [rrat_pkg::VERDICT_W-1:0] out_verdict_r;
  logic [rrat_pkg::SLOT_W-1:0]    out_slot_r;

  // Table memory
  rrat_pkg::entry_t mem [TABLE_SLOTS];
  rrat_pkg::entry_t rd_data_r;
  rrat_pkg::entry_t mem_wdata;
  logic             mem_we, mem_re;

  // Decode helpers
  logic                        id_bad, dev_bad, boot_bad, id_hit, same_body;
  logic                        scan_more, out_free, in_xfer;
  logic [IDX_W+rrat_pkg::SLOT_W-1:0] hit_ext, add_ext;

  function automatic logic uuid_ok(input logic [W-1:0] hi, input logic [W-1:0] lo);
    uuid_ok = (hi[15:12] == rrat_pkg::UUID_VERSION) &&
              (lo[W-1:W-2] == rrat_pkg::UUID_VARIANT);
  endfunction

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.verdict    = out_verdict_r;
  assign out_ch.slot_index = out_slot_r;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_dev_hi_r  <= '0;
      own_dev_lo_r  <= '0;
      own_boot_hi_r <= '0;
      own_boot_lo_r <= '0;
      window_r      <= rrat_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrat_pkg::CFG_OWN_DEVICE_HI: own_dev_hi_r  <= cfg_wdata;
        rrat_pkg::CFG_OWN_DEVICE_LO: own_dev_lo_r  <= cfg_wdata;
        rrat_pkg::CFG_OWN_BOOT_HI:   own_boot_hi_r <= cfg_wdata;
        rrat_pkg::CFG_OWN_BOOT_LO:   own_boot_lo_r <= cfg_wdata;
        rrat_pkg::CFG_WINDOW_MS:     window_r      <= cfg_wdata[rrat_pkg::WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the request on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_hi_r  <= in_ch.request_hi;
      req_lo_r  <= in_ch.request_lo;
      dev_hi_r  <= in_ch.claimed_device_hi;
      dev_lo_r  <= in_ch.claimed_device_lo;
      boot_hi_r <= in_ch.claimed_boot_hi;
      boot_lo_r <= in_ch.claimed_boot_lo;
      text_ok_r <= in_ch.text_form_ok;
      expiry_r  <= in_ch.expiry_ms;
      now_r     <= in_ch.now_ms;
      digest_r  <= in_ch.digest;
    end
  end

  // Latch time checks while identity is checked
  always_ff @(posedge clk) begin
    if (state_r == ST_CHECK) begin
      expired_r <= (expiry_r <= now_r);
      gap_r     <= expiry_r - now_r;
    end
  end

  // Identity and lookup decode
  assign id_bad   = !text_ok_r || !uuid_ok(req_hi_r, req_lo_r) ||
                    !uuid_ok(dev_hi_r, dev_lo_r) || !uuid_ok(boot_hi_r, boot_lo_r);
  assign dev_bad  = (dev_hi_r != own_dev_hi_r) || (dev_lo_r != own_dev_lo_r);
  assign boot_bad = (boot_hi_r != own_boot_hi_r) || (boot_lo_r != own_boot_lo_r);
  assign id_hit   = rd_vld_r && (rd_data_r.id_hi == req_hi_r) &&
                    (rd_data_r.id_lo == req_lo_r);
  assign same_body = (rd_data_r.expiry == expiry_r) && (rd_data_r.digest == digest_r);
  assign scan_more = (scan_r < count_r);

  // Slot numbers masked or extended to the output width
  assign hit_ext = {{rrat_pkg::SLOT_W{1'b0}}, rd_idx_r};
  assign add_ext = {{rrat_pkg::SLOT_W{1'b0}}, count_r[IDX_W-1:0]};

  assign mem_wdata = '{id_hi: req_hi_r, id_lo: req_lo_r, expiry: expiry_r,
                       digest: digest_r};

  // Sequencer: check, scan the table, decide
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    scan_nxt    = scan_r;
    rd_vld_nxt  = 1'b0;
    verdict_nxt = verdict_r;
    slot_nxt    = slot_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        scan_nxt = '0;
        slot_nxt = '0;
        if (id_bad) begin
          verdict_nxt = rrat_pkg::V_BAD_IDENTITY;
          state_nxt   = ST_DONE;
        end else if (dev_bad) begin
          verdict_nxt = rrat_pkg::V_WRONG_DEVICE;
          state_nxt   = ST_DONE;
        end else if (boot_bad) begin
          verdict_nxt = rrat_pkg::V_WRONG_BOOT;
          state_nxt   = ST_DONE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (id_hit) begin
          // First matching entry decides replay or conflict
          state_nxt = ST_DONE;
          if (same_body) begin
            verdict_nxt = rrat_pkg::V_REPLAY;
            slot_nxt    = hit_ext[rrat_pkg::SLOT_W-1:0];
          end else begin
            verdict_nxt = rrat_pkg::V_CONFLICT;
          end
        end else if (!rd_vld_r && !scan_more) begin
          // Miss: time window and capacity, then append
          state_nxt = ST_DONE;
          if (expired_r) begin
            verdict_nxt = rrat_pkg::V_EXPIRED;
          end else if (gap_r > {{(W-rrat_pkg::WINDOW_W){1'b0}}, window_r}) begin
            verdict_nxt = rrat_pkg::V_BAD_WINDOW;
          end else if (count_r == COUNT_W'(TABLE_SLOTS)) begin
            verdict_nxt = rrat_pkg::V_FULL;
          end else begin
            verdict_nxt = rrat_pkg::V_ACCEPT;
            slot_nxt    = add_ext[rrat_pkg::SLOT_W-1:0];
            mem_we      = 1'b1;
            count_nxt   = count_r + COUNT_W'(1);
          end
        end else if (scan_more) begin
          // Issue the next read
          mem_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          scan_nxt   = scan_r + COUNT_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  // Scan pointer and pending result
  always_ff @(posedge clk) begin
    scan_r    <= scan_nxt;
    verdict_r <= verdict_nxt;
    slot_r    <= slot_nxt;
    if (mem_re) rd_idx_r <= scan_r[IDX_W-1:0];
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[count_r[IDX_W-1:0]] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[scan_r[IDX_W-1:0]];
  end

  // Output register: load when free, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_verdict_r <= verdict_r;
      out_slot_r    <= slot_r;
    end
  end

endmodule

// File: hw/rtl/rrat_checker.sv
// ----------------------------------------------------------------------------
// rrat_checker
// Port-level checks for the request replay admission table.
// ----------------------------------------------------------------------------
module rrat_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rrat_pkg::VERDICT_W-1:0] out_verdict,
  input logic [rrat_pkg::SLOT_W-1:0]    out_slot_index
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict) &&
    $stable(out_slot_index))
    else $error("stalled result changed");

  // Report a slot only for replay or accept
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_slot_index != '0) |->
    (out_verdict == rrat_pkg::V_REPLAY) || (out_verdict == rrat_pkg::V_ACCEPT))
    else $error("slot reported for a verdict without a slot");

  // Drop ready while a request is in work
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken during work");

  // Come out of reset with no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind request_replay_admission_table_unit rrat_checker u_rrat_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_verdict    (out_ch.verdict),
  .out_slot_index (out_ch.slot_index)
);
